/* design/pinauth_pkg.sv */
// Shared widths, codes and types of the keypad PIN authenticator.
package pinauth_pkg;

  localparam int CODE_W        = 14;
  localparam int KEY_W         = 5;
  localparam int IDX_W         = 4;
  localparam int CMD_W         = 2;
  localparam int UNUM_W        = 5;
  localparam int CNT_W         = 2;
  localparam int KEYS_W        = 4;
  localparam int CFG_W         = 5;
  localparam int CFG_ADDR_W    = 2;
  localparam int RADIX         = 10;
  localparam int DIGITS_DEF    = 4;
  localparam int MAX_USERS_DEF = 16;

  // Stream payload layout
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Request kinds carried in tuser
  localparam logic [CMD_W-1:0] CMD_KEY     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ENROLLED  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEYS      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_KEY  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0]  ENROLLED_RST = 5'd0;
  localparam logic [KEYS_W-1:0] KEYS_RST     = 4'd10;
  localparam logic [KEY_W-1:0]  ZERO_KEY_RST = 5'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [UNUM_W-1:0] user;
  } scan_st_t;

endpackage

/* design/pin_code_user_authenticator.sv */
// Keypad PIN authenticator: digit collection, user table and sequential match.
// Timing: a request moves from idle to the response state, which publishes the result
//   once the output register is free; a key that completes a code first passes through the table scan.
// Throughput: one request at a time; ready stays low until the result is published.
// Reset (rst_n low, synchronous): clear code, digit count, success, user number,
//   sequencer and output valid; restore configuration defaults; keep the table.
module pin_code_user_authenticator
  import pinauth_pkg::*;
#(
  parameter int DIGITS    = DIGITS_DEF,
  parameter int MAX_USERS = MAX_USERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_code[4:0], entry_index[8:5], entry_code[22:9], zero pad [23]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // authenticated[0], user_number[5:1], mismatch[6], key_taken[7],
  // digits_entered[9:8], zero pad [15:10]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CW = $clog2(MAX_USERS + 1);

  // Request fields
  logic [KEY_W-1:0]  key_code;
  logic [IDX_W-1:0]  entry_index;
  logic [CODE_W-1:0] entry_code;
  logic              in_acc;

  assign key_code    = in_tdata[4:0];
  assign entry_index = in_tdata[8:5];
  assign entry_code  = in_tdata[22:9];
  assign in_acc      = in_tvalid && in_tready;

  // Configuration registers
  logic [CFG_W-1:0]  enrolled_r;
  logic [KEYS_W-1:0] keys_r;
  logic [KEY_W-1:0]  zero_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enrolled_r <= ENROLLED_RST;
      keys_r     <= KEYS_RST;
      zero_key_r <= ZERO_KEY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ENROLLED: enrolled_r <= cfg_wdata;
        CFG_KEYS:     keys_r     <= cfg_wdata[KEYS_W-1:0];
        CFG_ZERO_KEY: zero_key_r <= cfg_wdata;
        default:      ; // unused index: drop the write
      endcase
    end
  end

  // Clamp the enrolled count to the table size
  logic [CW-1:0] scan_count;
  assign scan_count = (32'(enrolled_r) > 32'(MAX_USERS)) ? CW'(MAX_USERS) : CW'(enrolled_r);

  // Authentication state
  state_t            state_r, state_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CNT_W-1:0]  digit_cnt_r, digit_cnt_nxt;
  logic              success_r, success_nxt;
  logic [UNUM_W-1:0] user_r, user_nxt;
  logic              miss_r, miss_nxt;
  logic              taken_r, taken_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Digit datapath
  logic              key_take;
  logic [CODE_W-1:0] code_step;

  pinauth_digit u_digit (
    .key_code    (key_code),
    .keys_in_use (keys_r),
    .zero_key    (zero_key_r),
    .locked      (success_r),
    .code        (code_r),
    .take        (key_take),
    .code_nxt    (code_step)
  );

  // User table
  logic              tbl_wr_en;
  logic              tbl_rd_en;
  logic [UW-1:0]     tbl_rd_addr;
  logic [CODE_W-1:0] tbl_rd_data;

  pinauth_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_USERS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (UW'(entry_index)),
    .wr_data (entry_code),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // Shared compare sequencer
  logic     scan_start;
  scan_st_t scan_st;

  pinauth_scan #(
    .MAX_USERS (MAX_USERS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .code    (code_step),
    .count   (scan_count),
    .rd_data (tbl_rd_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .status  (scan_st)
  );

  logic code_done;
  assign code_done = ({1'b0, digit_cnt_r} + 3'd1) >= 3'(DIGITS);

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    digit_cnt_nxt  = digit_cnt_r;
    success_nxt    = success_r;
    user_nxt       = user_r;
    miss_nxt       = miss_r;
    taken_nxt      = taken_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    tbl_wr_en      = 1'b0;
    scan_start     = 1'b0;
    in_tready      = (state_r == ST_IDLE);

    // Retire the held result once the sink takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          miss_nxt  = 1'b0;
          taken_nxt = 1'b0;
          state_nxt = ST_RESP;
          case (in_tuser)
            CMD_KEY: begin
              if (key_take) begin
                taken_nxt = 1'b1;
                if (code_done) begin
                  // full code: clear entry and scan the table
                  code_nxt      = '0;
                  digit_cnt_nxt = '0;
                  scan_start    = 1'b1;
                  state_nxt     = ST_SCAN;
                end else begin
                  code_nxt      = code_step;
                  digit_cnt_nxt = digit_cnt_r + CNT_W'(1);
                end
              end
            end
            CMD_LOAD: begin
              tbl_wr_en = (MAX_USERS >= 16) || (entry_index < IDX_W'(MAX_USERS));
            end
            CMD_RESTART: begin
              code_nxt      = '0;
              digit_cnt_nxt = '0;
              success_nxt   = 1'b0;
              user_nxt      = '0;
            end
            default: ; // unused request kind: change nothing
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_st.done) begin
          if (scan_st.hit) begin
            success_nxt = 1'b1;
            user_nxt    = scan_st.user;
          end else begin
            miss_nxt    = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        // Hold until the output register is free, then publish
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, digit_cnt_r, taken_r, miss_r,
                            success_r ? user_r : UNUM_W'(0), success_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      code_r       <= '0;
      digit_cnt_r  <= '0;
      success_r    <= 1'b0;
      user_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      code_r       <= code_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      success_r    <= success_nxt;
      user_r       <= user_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    miss_r      <= miss_nxt;
    taken_r     <= taken_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* design/pinauth_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pinauth_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/pinauth_digit.sv */
// Key qualification, digit mapping and decimal code accumulation.
module pinauth_digit
  import pinauth_pkg::*;
(
  input  logic [KEY_W-1:0]  key_code,
  input  logic [KEYS_W-1:0] keys_in_use,
  input  logic [KEY_W-1:0]  zero_key,
  input  logic              locked,
  input  logic [CODE_W-1:0] code,
  output logic              take,
  output logic [CODE_W-1:0] code_nxt
);

  logic [KEY_W-1:0] digit;

  always_comb begin
    take     = !locked && (key_code != '0) && (key_code <= {1'b0, keys_in_use});
    digit    = (key_code == zero_key) ? '0 : key_code;
    code_nxt = CODE_W'(code * CODE_W'(RADIX) + CODE_W'(digit));
  end

endmodule

/* design/pinauth_scan.sv */
// Table scan: one shared compare unit walks the enrolled entries, one per cycle.
module pinauth_scan
  import pinauth_pkg::*;
#(
  parameter int MAX_USERS = MAX_USERS_DEF,
  localparam int UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
  localparam int CW = $clog2(MAX_USERS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CODE_W-1:0] code,
  input  logic [CW-1:0]     count,
  input  logic [CODE_W-1:0] rd_data,
  output logic              rd_en,
  output logic [UW-1:0]     rd_addr,
  output scan_st_t          status
);

  logic              busy_r, busy_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [UW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CW-1:0]     cmp_num;

  always_comb begin
    rd_en   = busy_r && (scan_r < count_r);
    rd_addr = scan_r[UW-1:0];
    cmp_num = CW'(cmp_idx_r) + CW'(1);

    status      = '0;
    status.user = UNUM_W'(cmp_num);
    if (busy_r) begin
      if (cmp_vld_r && (rd_data == code_r)) begin
        status.done = 1'b1;
        status.hit  = 1'b1;
      end else if (cmp_vld_r && (cmp_num == count_r)) begin
        status.done = 1'b1;
      end else if (!cmp_vld_r && !rd_en) begin
        // empty table
        status.done = 1'b1;
      end
    end

    busy_nxt    = busy_r;
    cmp_vld_nxt = cmp_vld_r;
    scan_nxt    = scan_r;
    cmp_idx_nxt = cmp_idx_r;
    count_nxt   = count_r;
    code_nxt    = code_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cmp_vld_nxt = 1'b0;
      scan_nxt    = '0;
      count_nxt   = count;
      code_nxt    = code;
    end else if (status.done) begin
      busy_nxt    = 1'b0;
      cmp_vld_nxt = 1'b0;
    end else if (busy_r) begin
      cmp_vld_nxt = rd_en;
      cmp_idx_nxt = scan_r[UW-1:0];
      if (rd_en) begin
        scan_nxt = scan_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      busy_r    <= busy_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      scan_r    <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    count_r   <= count_nxt;
    code_r    <= code_nxt;
  end

endmodule

/* design/pinauth_checker.sv */
// Port-level checks of the PIN authenticator, bound to the top level.
module pinauth_checker
  import pinauth_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // One request in flight: ready drops after each accepted request
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // No user number without authentication
  a_user_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[5:1] == '0))
    else $error("user number shown while not authenticated");

  // A mismatch comes only from a taken key and never with success
  a_miss_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6]) |-> (out_tdata[7] && !out_tdata[0]))
    else $error("mismatch without a taken key or with success");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind pin_code_user_authenticator pinauth_checker u_pinauth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
